[src/mrh_pkg.sv]
`timescale 1ns / 1ps

package mrh_pkg;

  typedef logic [2:0]  action_t;
  typedef logic [2:0]  baud_t;
  typedef logic [7:0]  char_t;
  typedef logic [15:0] timeout_t;

  // result codes
  localparam action_t ACT_NONE    = 3'd0;
  localparam action_t ACT_SEND_ID = 3'd1;
  localparam action_t ACT_ERROR   = 3'd2;
  localparam action_t ACT_SILENT  = 3'd3;
  localparam action_t ACT_DATASET = 3'd4;

  localparam timeout_t TIMEOUT_RESET = 16'd2000;

  // characters of the request "/?!" CR LF and the option select message
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_QUEST = 8'h3F;
  localparam char_t CH_EXCL  = 8'h21;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_ACK   = 8'h06;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_SIX   = 8'h36;
  localparam char_t CH_UPA   = 8'h41;
  localparam char_t CH_UPF   = 8'h46;

  localparam logic [2:0] REQ_LAST = 3'd4;
  localparam baud_t      BAUD_BAD = 3'd7;

  typedef struct packed {
    logic  opcode;   // 1 = millisecond tick
    char_t rx_byte;
  } item_t;

  typedef struct packed {
    action_t action;
    baud_t   baud_index;
  } result_t;

  // expected request character at a given match position
  function automatic char_t req_char(input logic [2:0] idx);
    char_t c;
    case (idx)
      3'd0:    c = CH_SLASH;
      3'd1:    c = CH_QUEST;
      3'd2:    c = CH_EXCL;
      3'd3:    c = CH_CR;
      3'd4:    c = CH_LF;
      default: c = CH_SLASH;
    endcase
    return c;
  endfunction

  // Z character to speed index; BAUD_BAD when not a valid speed
  function automatic baud_t map_speed(input char_t z);
    baud_t s;
    if (z >= CH_ZERO && z <= CH_SIX) begin
      s = 3'(z - CH_ZERO);
    end else if (z >= CH_UPA && z <= CH_UPF) begin
      s = 3'(z - CH_UPA + 8'd1);
    end else begin
      s = BAUD_BAD;
    end
    return s;
  endfunction

endpackage

[src/mrh_if.sv]
`timescale 1ns / 1ps

interface mrh_item_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  mrh_pkg::char_t      rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mrh_result_if;
  logic                valid;
  logic                ready;
  mrh_pkg::action_t    action;
  mrh_pkg::baud_t      baud_index;
  modport source (output valid, output action, output baud_index, input ready);
  modport sink   (input valid, input action, input baud_index, output ready);
endinterface

interface mrh_cfg_if;
  logic                valid;
  logic                ready;
  mrh_pkg::timeout_t   timeout_ms;
  modport source (output valid, output timeout_ms, input ready);
  modport sink   (input valid, input timeout_ms, output ready);
endinterface

[src/mrh_core.sv]
`timescale 1ns / 1ps

module mrh_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mrh_pkg::item_t     item_in,
  input  mrh_pkg::timeout_t  timeout_ms,
  output mrh_pkg::result_t   result_out
);

  typedef enum logic {
    PH_REQUEST,
    PH_OPTION
  } phase_t;

  phase_t             phase, phase_next;
  logic [2:0]         match_index, match_index_next;
  mrh_pkg::timeout_t  countdown, countdown_next;
  logic [2:0]         option_index, option_index_next;
  mrh_pkg::char_t     opt_v, opt_z, opt_y;
  mrh_pkg::result_t   res_next;

  logic               expire;
  mrh_pkg::baud_t     z_speed;
  logic               restart;

  assign expire  = (countdown <= 16'd1);
  assign z_speed = mrh_pkg::map_speed(opt_z);

  always_comb begin
    phase_next          = phase;
    match_index_next    = match_index;
    countdown_next      = countdown;
    option_index_next   = option_index;
    res_next.action     = mrh_pkg::ACT_NONE;
    res_next.baud_index = 3'd0;
    restart             = 1'b0;

    unique case (phase)
      PH_REQUEST: begin
        if (item_in.opcode) begin
          // timer runs only once a first request byte is in
          if (match_index != 3'd0) begin
            if (expire) begin
              restart         = 1'b1;
              res_next.action = mrh_pkg::ACT_ERROR;
            end else begin
              countdown_next = countdown - 16'd1;
            end
          end
        end else if (item_in.rx_byte == mrh_pkg::req_char(match_index)) begin
          if (match_index == mrh_pkg::REQ_LAST) begin
            phase_next        = PH_OPTION;
            match_index_next  = 3'd0;
            countdown_next    = timeout_ms;
            option_index_next = 3'd0;
            res_next.action   = mrh_pkg::ACT_SEND_ID;
          end else begin
            match_index_next = match_index + 3'd1;
          end
        end else begin
          // mismatch: restart match, timer keeps running
          match_index_next = 3'd0;
          res_next.action  = mrh_pkg::ACT_ERROR;
        end
      end
      PH_OPTION: begin
        if (item_in.opcode) begin
          if (expire) begin
            restart         = 1'b1;
            res_next.action = (option_index == 3'd0) ? mrh_pkg::ACT_DATASET
                                                     : mrh_pkg::ACT_SILENT;
          end else begin
            countdown_next = countdown - 16'd1;
          end
        end else begin
          case (option_index)
            3'd0: begin
              if (item_in.rx_byte == mrh_pkg::CH_ACK) begin
                option_index_next = 3'd1;
              end else begin
                restart         = 1'b1;
                res_next.action = mrh_pkg::ACT_ERROR;
              end
            end
            3'd1, 3'd2, 3'd3: begin
              option_index_next = option_index + 3'd1;
            end
            3'd4: begin
              if (item_in.rx_byte == mrh_pkg::CH_CR) begin
                option_index_next = 3'd5;
              end else begin
                restart         = 1'b1;
                res_next.action = mrh_pkg::ACT_ERROR;
              end
            end
            default: begin
              restart = 1'b1;
              if (item_in.rx_byte == mrh_pkg::CH_LF && opt_v == mrh_pkg::CH_ZERO &&
                  z_speed != mrh_pkg::BAUD_BAD && opt_y == mrh_pkg::CH_ZERO) begin
                res_next.action     = mrh_pkg::ACT_DATASET;
                res_next.baud_index = z_speed;
              end else begin
                res_next.action = mrh_pkg::ACT_ERROR;
              end
            end
          endcase
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      phase_next        = PH_REQUEST;
      match_index_next  = 3'd0;
      countdown_next    = timeout_ms;
      option_index_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_REQUEST;
      match_index  <= 3'd0;
      countdown    <= mrh_pkg::TIMEOUT_RESET;
      option_index <= 3'd0;
    end else if (step) begin
      phase        <= phase_next;
      match_index  <= match_index_next;
      countdown    <= countdown_next;
      option_index <= option_index_next;
    end
  end

  // option bytes V, Z, Y and the result register: payload, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      result_out <= res_next;
      if (phase == PH_OPTION && !item_in.opcode) begin
        if (option_index == 3'd1) opt_v <= item_in.rx_byte;
        if (option_index == 3'd2) opt_z <= item_in.rx_byte;
        if (option_index == 3'd3) opt_y <= item_in.rx_byte;
      end
    end
  end

endmodule

[src/meter_readout_handshake.sv]
`timescale 1ns / 1ps

// Meter-side optical readout handshake (mode C style, data readout only).
// Each transaction on item carries either a received byte (opcode 0) or a
// one-millisecond tick (opcode 1) and produces exactly one transaction on
// result: action 0 none, 1 send identification, 2 error and restart,
// 3 silent restart, 4 send dataset, with baud_index giving the line speed
// (nonzero only for a dataset started by a valid option select message).
// Timing: one transaction accepted per clock while result does not stall; a
// result is valid on result once its item has passed the input register and
// then the result register that holds the state update. result backpressure
// stalls both stages, but item stays ready while the input register is free.
// The timeout_ms register (reset 2000) is written over cfg, which is always
// ready; write it only while the block is idle. A new value takes effect at
// the next reload of the countdown.
module meter_readout_handshake (
  input  logic               clk,
  input  logic               rst,
  mrh_item_if.sink           item,
  mrh_result_if.source       result,
  mrh_cfg_if.sink            cfg
);

  mrh_pkg::timeout_t  timeout_ms;

  // input register
  logic               in_valid;
  mrh_pkg::item_t     in_item;

  // result register valid
  logic               out_valid;
  mrh_pkg::result_t   out_res;

  logic               advance;
  logic               step;

  assign advance    = !out_valid || result.ready;
  assign step       = in_valid && advance;
  assign item.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= mrh_pkg::TIMEOUT_RESET;
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) timeout_ms <= cfg.timeout_ms;
      // input stage refills in the same cycle it drains
      if (item.valid && item.ready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.opcode  <= item.opcode;
      in_item.rx_byte <= item.rx_byte;
    end
  end

  mrh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item_in    (in_item),
    .timeout_ms (timeout_ms),
    .result_out (out_res)
  );

  assign result.valid      = out_valid;
  assign result.action     = out_res.action;
  assign result.baud_index = out_res.baud_index;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mrh_pkg::*;

  localparam int   REQ_LEN        = 5;
  localparam int   PHASE_ITEMS    = 155;
  localparam int   IDLE_LIMIT     = 5000;  // cycles with no transaction anywhere
  localparam int   HOLD_OFF       = 240;   // long receiver stall, in cycles
  localparam int   MAX_PRINTS     = 40;
  // option-select positions that check a fixed character
  localparam logic [2:0] OPT_WAIT_ACK = 3'd0;
  localparam logic [2:0] OPT_WAIT_CR  = 3'd4;
  localparam logic [2:0] OPT_WAIT_LF  = 3'd5;
  // request "/?!" CR LF, first character in the low byte
  localparam logic [39:0] REQUEST_SEQ = {CH_LF, CH_CR, CH_EXCL, CH_QUEST, CH_SLASH};

  logic clk;
  logic rst;

  mrh_item_if   item_ch ();
  mrh_result_if result_ch ();
  mrh_cfg_if    cfg_ch ();

  meter_readout_handshake DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // stimulus still to be offered, and results still owed by the block
  item_t   readout_stim[$];
  result_t expected_results[$];

  int mismatches   = 0;
  int queued_items = 0;
  int results_seen = 0;

  // ---------------------------------------------------------------------------
  // Meter state as the testbench tracks it
  // ---------------------------------------------------------------------------
  logic      mtr_phase;      // 0 request, 1 option select
  logic [2:0] mtr_match;
  timeout_t  mtr_countdown;
  timeout_t  mtr_timeout;    // copy of the register
  logic [2:0] mtr_opt_idx;
  char_t     mtr_opt[3];     // V, Z, Y
  baud_t     mtr_speed;

  task automatic restart_meter();
    mtr_phase     = 1'b0;
    mtr_match     = '0;
    mtr_countdown = mtr_timeout;
    mtr_opt_idx   = OPT_WAIT_ACK;
    mtr_speed     = '0;
  endtask

  // A tick at countdown 0 or 1 expires; so a register of 0 acts like 1.
  function automatic bit countdown_expired();
    if (mtr_countdown <= 16'd1) begin
      mtr_countdown = '0;
      return 1'b1;
    end
    mtr_countdown = mtr_countdown - 16'd1;
    return 1'b0;
  endfunction

  // Works out the one result caused by an accepted item and queues it.
  task automatic predict_meter_action(input logic is_tick, input char_t b);
    result_t r;
    baud_t   sp;
    bit      speed_given;
    r.action    = ACT_NONE;
    r.baud_index = '0;
    speed_given = 1'b0;
    if (!mtr_phase) begin
      if (is_tick) begin
        // ticks only count once a first request character is in
        if (mtr_match != 0 && countdown_expired()) begin
          restart_meter();
          r.action = ACT_ERROR;
        end
      end else if (b == REQUEST_SEQ[8*mtr_match +: 8]) begin
        mtr_match = mtr_match + 3'd1;
        if (mtr_match == REQ_LEN) begin
          mtr_phase     = 1'b1;
          mtr_countdown = mtr_timeout;
          mtr_opt_idx   = OPT_WAIT_ACK;
          r.action      = ACT_SEND_ID;
        end
      end else begin
        // wrong byte: match starts over, timer keeps running
        mtr_match = '0;
        r.action  = ACT_ERROR;
      end
    end else if (is_tick) begin
      if (countdown_expired()) begin
        if (mtr_opt_idx == OPT_WAIT_ACK) begin
          // no reply at all: dataset at the current speed
          r.action     = ACT_DATASET;
          r.baud_index = mtr_speed;
          speed_given  = 1'b1;
        end else begin
          r.action = ACT_SILENT;
        end
        restart_meter();
      end
    end else begin
      case (mtr_opt_idx)
        OPT_WAIT_ACK: begin
          if (b != CH_ACK) begin
            restart_meter();
            r.action = ACT_ERROR;
          end else begin
            mtr_opt_idx = mtr_opt_idx + 3'd1;
          end
        end
        OPT_WAIT_CR: begin
          if (b != CH_CR) begin
            restart_meter();
            r.action = ACT_ERROR;
          end else begin
            mtr_opt_idx = OPT_WAIT_LF;
          end
        end
        OPT_WAIT_LF: begin
          if (mtr_opt[1] >= CH_ZERO && mtr_opt[1] <= CH_SIX) begin
            sp = 3'(mtr_opt[1] - CH_ZERO);
          end else if (mtr_opt[1] >= CH_UPA && mtr_opt[1] <= CH_UPF) begin
            sp = 3'(mtr_opt[1] - CH_UPA + 8'd1);
          end else begin
            sp = BAUD_BAD;
          end
          if (b != CH_LF || mtr_opt[0] != CH_ZERO || sp == BAUD_BAD ||
              mtr_opt[2] != CH_ZERO) begin
            restart_meter();
            r.action = ACT_ERROR;
          end else begin
            mtr_speed    = sp;
            r.action     = ACT_DATASET;
            r.baud_index = sp;
            speed_given  = 1'b1;
            restart_meter();
          end
        end
        default: begin
          // V, Z, Y are stored as they come, checked at LF
          mtr_opt[mtr_opt_idx - 3'd1] = b;
          mtr_opt_idx = mtr_opt_idx + 3'd1;
        end
      endcase
    end
    if (!speed_given) r.baud_index = mtr_speed;
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic is_tick, input char_t b);
    item_t it;
    it.opcode  = is_tick;
    it.rx_byte = b;
    readout_stim.push_back(it);
    queued_items++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_item(1'b1, char_t'($urandom));
  endtask

  // occasional stray tick between characters
  task automatic push_char(input char_t b);
    if ($urandom_range(0, 99) < 12) push_ticks(1);
    push_item(1'b0, b);
  endtask

  // Z: mostly a valid speed, sometimes a neighbor of the valid ranges
  function automatic char_t pick_speed_char();
    int k;
    k = $urandom_range(0, 19);
    if (k < 7) return CH_ZERO + char_t'($urandom_range(0, 6));
    if (k < 13) return CH_UPA + char_t'($urandom_range(0, 5));
    case (k)
      13:      return CH_ZERO - 8'd1;
      14:      return CH_SIX + 8'd1;
      15:      return CH_UPA - 8'd1;
      16:      return CH_UPF + 8'd1;
      17:      return CH_UPA + 8'h20;   // lower case is not accepted
      default: return char_t'($urandom);
    endcase
  endfunction

  function automatic char_t mostly_zero_char();
    if ($urandom_range(0, 9) == 0) return char_t'($urandom);
    return CH_ZERO;
  endfunction

  // One readout attempt, well formed most of the time.
  task automatic queue_session(input int tmo);
    int    kind;
    int    cut;
    int    expire_ticks;
    char_t msg[6];
    expire_ticks = (tmo == 0) ? 2 : tmo + 1;
    // with a long timeout only a few ticks, no expiry
    if (expire_ticks > 64) expire_ticks = $urandom_range(1, 4);
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // request broken by a wrong character
      cut = $urandom_range(0, REQ_LEN - 1);
      for (int i = 0; i < cut; i++) push_char(REQUEST_SEQ[8*i +: 8]);
      push_char(char_t'($urandom));
    end else if (kind < 20) begin
      // partial request, then silence until timeout
      cut = $urandom_range(1, REQ_LEN - 1);
      for (int i = 0; i < cut; i++) push_char(REQUEST_SEQ[8*i +: 8]);
      push_ticks(expire_ticks);
    end else if (kind < 28) begin
      // line noise
      repeat ($urandom_range(1, 8)) push_item(1'($urandom), char_t'($urandom));
    end else begin
      for (int i = 0; i < REQ_LEN; i++) push_char(REQUEST_SEQ[8*i +: 8]);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // host never answers: dataset at the initial speed
        push_ticks(expire_ticks);
      end else begin
        msg[0] = (kind < 14) ? char_t'($urandom) : CH_ACK;
        msg[1] = mostly_zero_char();
        msg[2] = pick_speed_char();
        msg[3] = mostly_zero_char();
        msg[4] = CH_CR;
        msg[5] = CH_LF;
        kind = $urandom_range(0, 99);
        if (kind < 4) msg[4] = char_t'($urandom);
        else if (kind < 8) msg[5] = char_t'($urandom);
        if ($urandom_range(0, 99) < 10) begin
          // truncated message, then timeout
          cut = $urandom_range(1, 5);
          for (int i = 0; i < cut; i++) push_char(msg[i]);
          push_ticks(expire_ticks);
        end else begin
          for (int i = 0; i < 6; i++) push_char(msg[i]);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers readout_stim in bursts with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  function automatic int next_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 0;                 // back-to-back stretch
    if (k < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_meter_action(item_ch.opcode, item_ch.rx_byte);
        void'(readout_stim.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = next_gap();
        end
      end
      if (item_ch.valid && !item_ch.ready) begin
        // stalled: keep the same transaction on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (readout_stim.size() > 0) begin
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= readout_stim[0].opcode;
        item_ch.rx_byte <= readout_stim[0].rx_byte;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results in order, stalls on a pattern of its own
  // ---------------------------------------------------------------------------
  int   pattern_left = 0;
  int   stall_mode   = 0;
  int   hold_left    = 0;
  logic ready_next;
  result_t got_expected;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending, action", -1, result_ch.action);
        end else begin
          got_expected = expected_results.pop_front();
          if (result_ch.action != got_expected.action)
            report_mismatch("action", got_expected.action, result_ch.action);
          if (result_ch.baud_index != got_expected.baud_index)
            report_mismatch("baud_index", got_expected.baud_index, result_ch.baud_index);
        end
        results_seen++;
        // long hold-off twice in the run; sender keeps offering meanwhile
        if (results_seen == 400 || results_seen == 1000) hold_left = HOLD_OFF;
      end
      if (pattern_left == 0) begin
        pattern_left = 64;
        stall_mode   = $urandom_range(0, 3);
      end else begin
        pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (stall_mode)
          0:       ready_next = 1'b1;                          // no stalls
          1:       ready_next = ($urandom_range(0, 3) != 0);   // light stalls
          2:       ready_next = ~result_ch.ready;              // alternating ready
          default: ready_next = ($urandom_range(0, 3) == 0);   // heavy stalls
        endcase
      end
      result_ch.ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction means the block hung
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: directed part, then random phases under several timeouts
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (readout_stim.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // two-stage pipe, plus margin
  endtask

  task automatic write_timeout(input timeout_t value);
    @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.timeout_ms <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    mtr_timeout = value;  // applies at the next countdown reload
    cfg_ch.valid <= 1'b0;
  endtask

  timeout_t phase_timeouts[8];

  initial begin
    // known values on every input before the first edge
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.opcode    = 1'b0;
    item_ch.rx_byte   = '0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.timeout_ms = '0;
    mtr_timeout       = TIMEOUT_RESET;
    mtr_opt[0]        = '0;
    mtr_opt[1]        = '0;
    mtr_opt[2]        = '0;
    restart_meter();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset timeout
    push_item(1'b1, 8'hFF);        // tick before any request byte: nothing
    push_item(1'b0, 8'hFF);        // wrong first byte
    push_item(1'b0, CH_SLASH);
    push_item(1'b0, CH_QUEST);
    push_item(1'b0, 8'h00);        // wrong byte mid-request, match restarts
    push_item(1'b1, 8'h00);        // tick after the restart: match is back at 0, no countdown
    for (int i = 0; i < REQ_LEN; i++) push_item(1'b0, REQUEST_SEQ[8*i +: 8]);
    push_item(1'b0, CH_ACK);
    push_item(1'b0, CH_ZERO);
    push_item(1'b0, CH_SIX);       // top speed
    push_item(1'b0, CH_ZERO);
    push_item(1'b0, CH_CR);
    push_item(1'b0, CH_LF);
    for (int i = 0; i < REQ_LEN; i++) push_item(1'b0, REQUEST_SEQ[8*i +: 8]);
    push_item(1'b0, CH_SLASH);     // not ACK in option select
    wait_idle();

    // extremes first, then a mix of short timeouts so expiry happens often
    phase_timeouts[0] = 16'd1;
    phase_timeouts[1] = 16'd0;
    phase_timeouts[2] = 16'hFFFF;
    phase_timeouts[3] = 16'd2;
    phase_timeouts[4] = timeout_t'($urandom_range(3, 40));
    phase_timeouts[5] = 16'd7;
    phase_timeouts[6] = timeout_t'($urandom_range(2, 16));
    phase_timeouts[7] = 16'd1;

    foreach (phase_timeouts[p]) begin
      write_timeout(phase_timeouts[p]);
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) queue_session(phase_timeouts[p]);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/mrh_pkg.sv
src/mrh_if.sv
src/mrh_core.sv
src/meter_readout_handshake.sv
dv/tb.sv
